/* rtl/core/radec_to_lmn_direction_cosines_macros.svh */
// Assertion macros shared by the direction cosine RTL.
// Expects clk and rst in the scope of each use; no other dependencies.
`ifndef RADEC_TO_LMN_DIRECTION_COSINES_MACROS_SVH
`define RADEC_TO_LMN_DIRECTION_COSINES_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RLMN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("direction cosine check failed");

// Next-cycle implication, checked outside reset.
`define RLMN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("direction cosine check failed");

`endif

/* rtl/core/rdlmn_pkg.sv */
// Constants, types and arithmetic helpers for the direction cosine pipeline.
// No dependencies; the CORDIC tables are built at elaboration.
package rdlmn_pkg;

  localparam int unsigned ANGLE_BITS    = 32;
  localparam int unsigned OUT_FRAC_BITS = 30;
  localparam int unsigned CORDIC_STAGES = 32;
  localparam int unsigned WF            = 60;
  localparam int unsigned OUT_SHIFT     = WF - OUT_FRAC_BITS;
  localparam int unsigned ROOT_BITS     = WF + 1;
  localparam int unsigned REM_BITS      = 2 * ROOT_BITS;
  localparam int unsigned LANES         = 4;

  localparam logic [63:0] ONE = 64'(1) << WF;
  localparam logic signed [31:0] OUT_ONE = 32'sd1 <<< OUT_FRAC_BITS;

  // Lane order inside the CORDIC bank
  localparam int unsigned LN_DEC  = 0;
  localparam int unsigned LN_DEC0 = 1;
  localparam int unsigned LN_HOUR = 2;
  localparam int unsigned LN_ROT  = 3;

  typedef logic [CORDIC_STAGES-1:0][63:0] atan_tab_t;

  typedef struct packed {
    logic [1:0]         quad;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } cord_t;

  typedef struct packed {
    logic signed [63:0] c;
    logic signed [63:0] s;
  } sc_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] ll;
    logic [63:0] hl;
    logic [63:0] lh;
    logic [63:0] hh;
  } prod_t;

  // Elaboration-only helpers: bitwise long division and exact constants.
  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      q = q << 1;
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] atan_inv(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] n2;
    logic [63:0] k;
    p = udiv(64'(1) << 62, n);
    sum = p;
    n2 = n * n;
    k = 64'd1;
    while (p != '0) begin
      p = udiv(p, n2);
      if (k[0]) sum = sum - udiv(p, 2 * k + 64'd1);
      else sum = sum + udiv(p, 2 * k + 64'd1);
      k = k + 64'd1;
    end
    return sum;
  endfunction

  function automatic logic [63:0] atan_pow2(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int k;
    int sh;
    sum = '0;
    k = 0;
    sh = 62 - i;
    while (sh >= 0) begin
      term = udiv(64'(1) << sh, 64'(2 * k + 1));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
      k = k + 1;
      sh = 62 - i * (2 * k + 1);
    end
    return sum;
  endfunction

  function automatic logic [63:0] mulu_c(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b} + (128'(1) << (WF - 1));
    return p[WF+63:WF];
  endfunction

  function automatic atan_tab_t atan_table();
    atan_tab_t t;
    logic [63:0] qp;
    logic [63:0] r;
    logic [63:0] q;
    qp = 64'd4 * atan_inv(64'd5) - atan_inv(64'd239);
    t = '0;
    t[0] = 64'(1) << 61;
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      r = atan_pow2(i);
      q = '0;
      for (int b = 0; b < 61; b++) begin
        r = r << 1;
        q = q << 1;
        if (r >= qp) begin
          r = r - qp;
          q[0] = 1'b1;
        end
      end
      t[i] = q;
    end
    return t;
  endfunction

  function automatic logic [63:0] inv_gain_calc();
    logic [63:0] g2;
    logic [63:0] y;
    logic [63:0] t;
    g2 = ONE;
    for (int i = 0; i < CORDIC_STAGES; i++)
      if (2 * i < 64) g2 = g2 + (g2 >> (2 * i));
    y = '0;
    for (int b = WF; b >= 0; b--) begin
      t = y | (64'(1) << b);
      if (mulu_c(mulu_c(t, t), g2) <= ONE) y = t;
    end
    return y;
  endfunction

  localparam atan_tab_t   ATAN_TAB = atan_table();
  localparam logic [63:0] INV_GAIN = inv_gain_calc();

  // Hardware helpers
  function automatic logic [63:0] to_angle(input logic [31:0] v);
    return {v[ANGLE_BITS-1:0], {(64 - ANGLE_BITS){1'b0}}};
  endfunction

  function automatic cord_t cordic_init(input logic [63:0] a);
    cord_t c;
    logic [63:0] sum;
    sum = a + (64'(1) << 61);
    c.quad = sum[63:62];
    c.z = $signed(a - {c.quad, 62'b0});
    c.x = $signed(INV_GAIN);
    c.y = '0;
    return c;
  endfunction

  function automatic cord_t cordic_step(input cord_t c, input int unsigned i);
    cord_t o;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    dx = c.y >>> i;
    dy = c.x >>> i;
    o.quad = c.quad;
    if (!c.z[63]) begin
      o.x = c.x - dx;
      o.y = c.y + dy;
      o.z = c.z - $signed(ATAN_TAB[i]);
    end else begin
      o.x = c.x + dx;
      o.y = c.y - dy;
      o.z = c.z + $signed(ATAN_TAB[i]);
    end
    return o;
  endfunction

  function automatic sc_t cordic_fix(input cord_t c);
    sc_t o;
    case (c.quad)
      2'd0: begin o.c = c.x;  o.s = c.y;  end
      2'd1: begin o.c = -c.y; o.s = c.x;  end
      2'd2: begin o.c = -c.x; o.s = -c.y; end
      default: begin o.c = c.y; o.s = -c.x; end
    endcase
    return o;
  endfunction

  // Product, first half: magnitudes and four 32x32 partial products.
  function automatic prod_t mul_part(input logic signed [63:0] a,
                                     input logic signed [63:0] b);
    prod_t p;
    logic [63:0] ma;
    logic [63:0] mb;
    ma = a[63] ? 64'(-a) : 64'(a);
    mb = b[63] ? 64'(-b) : 64'(b);
    p.neg = a[63] ^ b[63];
    p.ll = 64'(ma[31:0]) * 64'(mb[31:0]);
    p.hl = 64'(ma[63:32]) * 64'(mb[31:0]);
    p.lh = 64'(ma[31:0]) * 64'(mb[63:32]);
    p.hh = 64'(ma[63:32]) * 64'(mb[63:32]);
    return p;
  endfunction

  // Product, second half: sum, round half up, saturate, apply sign.
  function automatic logic signed [63:0] mul_done(input prod_t p);
    logic [127:0] full;
    logic [63:0] r;
    full = {p.hh, 64'b0} + ({64'b0, p.hl} << 32) + ({64'b0, p.lh} << 32)
         + {64'b0, p.ll} + (128'(1) << (WF - 1));
    r = full[WF+63:WF];
    if (r[63]) r = {1'b0, {63{1'b1}}};
    return p.neg ? $signed(-r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] to_out(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (t > 64'(OUT_ONE)) t = 64'(OUT_ONE);
    if (t < -64'(OUT_ONE)) t = -64'(OUT_ONE);
    return t[31:0];
  endfunction

endpackage

/* rtl/core/radec_to_lmn_direction_cosines.sv */
// Direction cosines (l, m, n) of a source against a phase centre, fully pipelined.
// Depends on rdlmn_pkg and radec_to_lmn_direction_cosines_macros.svh.
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------------
//  request | in_valid / in_stall | mode, center_ra, center_dec, source_ra,
//          |                     | source_dec, rotation_angle
//  result  | out_valid/out_stall | l_cosine, m_cosine, n_cosine, n_clamped
//
// One request enters per cycle unless in_stall is high; each result passes through 1 input stage,
// 32 CORDIC stages, 12 multiply/add stages, 61 square root stages and 1 output register.
// The CORDIC bank and the restoring square root set the depth.
// rst (synchronous) clears every valid bit; payload registers are not reset.
// A held result only stalls the request side while the last pipeline stage is full;
// bubbles ahead of it keep closing up, and a stall never drops or repeats a request.
`include "radec_to_lmn_direction_cosines_macros.svh"

module radec_to_lmn_direction_cosines (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [31:0]        center_ra,
  input  logic signed [31:0] center_dec,
  input  logic [31:0]        source_ra,
  input  logic signed [31:0] source_dec,
  input  logic [31:0]        rotation_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] l_cosine,
  output logic signed [31:0] m_cosine,
  output logic [30:0]        n_cosine,
  output logic               n_clamped
);
  import rdlmn_pkg::*;

  typedef struct packed {
    logic               mode;
    cord_t [LANES-1:0]  ln;
  } cst_t;

  typedef struct packed {
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] y;
    logic                 flag;
    logic signed [31:0]   lo;
    logic signed [31:0]   mo;
  } sq_t;

  // Global advance: hold everything only when the output is held and the
  // last stage has something to hand over.
  logic out_hold;
  logic adv;

  assign out_hold = out_valid && out_stall;

  // ---------------------------------------------------------------------------
  // CORDIC bank: four lanes (dec, dec0, hour angle, position angle)
  // ---------------------------------------------------------------------------
  logic cv [CORDIC_STAGES+1];
  cst_t cs [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else if (adv) cv[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs[0].mode <= mode;
      cs[0].ln[LN_DEC] <= cordic_init(to_angle(source_dec));
      cs[0].ln[LN_DEC0] <= cordic_init(to_angle(center_dec));
      cs[0].ln[LN_HOUR] <= cordic_init(to_angle(source_ra) - to_angle(center_ra));
      cs[0].ln[LN_ROT] <= cordic_init(to_angle(rotation_angle));
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) cv[k+1] <= 1'b0;
      else if (adv) cv[k+1] <= cv[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cs[k+1].mode <= cs[k].mode;
        for (int j = 0; j < LANES; j++)
          cs[k+1].ln[j] <= cordic_step(cs[k].ln[j], k);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Quadrant fix-up, products, rotation and radicand
  // ---------------------------------------------------------------------------
  logic  qv, m1av, m1bv, m2av, m2bv, d2v, m3av, m3bv, r3v, m4av, m4bv;
  logic  qmode, m1amode, m1bmode, m2amode, m2bmode, d2mode, m3amode, m3bmode;
  sc_t   qsc [LANES];

  prod_t m1a_p [3];
  logic signed [63:0] m1a_ch, m1a_cp, m1a_sp;
  logic signed [63:0] m1b_l, m1b_t1, m1b_t2, m1b_ch, m1b_cp, m1b_sp;

  prod_t m2a_p;
  logic signed [63:0] m2a_l, m2a_t1, m2a_cp, m2a_sp;
  logic signed [63:0] m2b_l, m2b_t1, m2b_t3, m2b_cp, m2b_sp;

  logic signed [63:0] d2_l, d2_m, d2_cp, d2_sp;

  prod_t m3a_p [4];
  logic signed [63:0] m3a_l, m3a_m;
  logic signed [63:0] m3b_r [4];
  logic signed [63:0] m3b_l, m3b_m;

  logic signed [63:0] r3_l, r3_m;

  prod_t m4a_p [2];
  logic signed [63:0] m4a_l, m4a_m;
  logic signed [63:0] m4b_ll, m4b_mm, m4b_l, m4b_m;

  logic signed [63:0] d4_d;
  assign d4_d = $signed(ONE) - m4b_ll - m4b_mm;

  logic sv [ROOT_BITS+1];
  sq_t  sq [ROOT_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0; m1av <= 1'b0; m1bv <= 1'b0; m2av <= 1'b0; m2bv <= 1'b0;
      d2v <= 1'b0; m3av <= 1'b0; m3bv <= 1'b0; r3v <= 1'b0; m4av <= 1'b0;
      m4bv <= 1'b0; sv[0] <= 1'b0;
    end else if (adv) begin
      qv <= cv[CORDIC_STAGES];
      m1av <= qv; m1bv <= m1av; m2av <= m1bv; m2bv <= m2av; d2v <= m2bv;
      m3av <= d2v; m3bv <= m3av; r3v <= m3bv; m4av <= r3v; m4bv <= m4av;
      sv[0] <= m4bv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Map each CORDIC result back to its quadrant
      qmode <= cs[CORDIC_STAGES].mode;
      for (int j = 0; j < LANES; j++) qsc[j] <= cordic_fix(cs[CORDIC_STAGES].ln[j]);

      // l = cos(dec) sin(h); first terms of m
      m1amode <= qmode;
      m1a_p[0] <= mul_part(qsc[LN_DEC].c, qsc[LN_HOUR].s);
      m1a_p[1] <= mul_part(qsc[LN_DEC].s, qsc[LN_DEC0].c);
      m1a_p[2] <= mul_part(qsc[LN_DEC].c, qsc[LN_DEC0].s);
      m1a_ch <= qsc[LN_HOUR].c;
      m1a_cp <= qsc[LN_ROT].c;
      m1a_sp <= qsc[LN_ROT].s;

      m1bmode <= m1amode;
      m1b_l <= mul_done(m1a_p[0]);
      m1b_t1 <= mul_done(m1a_p[1]);
      m1b_t2 <= mul_done(m1a_p[2]);
      m1b_ch <= m1a_ch; m1b_cp <= m1a_cp; m1b_sp <= m1a_sp;

      // cos(dec) sin(dec0) cos(h)
      m2amode <= m1bmode;
      m2a_p <= mul_part(m1b_t2, m1b_ch);
      m2a_l <= m1b_l; m2a_t1 <= m1b_t1; m2a_cp <= m1b_cp; m2a_sp <= m1b_sp;

      m2bmode <= m2amode;
      m2b_t3 <= mul_done(m2a_p);
      m2b_l <= m2a_l; m2b_t1 <= m2a_t1; m2b_cp <= m2a_cp; m2b_sp <= m2a_sp;

      d2mode <= m2bmode;
      d2_m <= m2b_t1 - m2b_t3;
      d2_l <= m2b_l; d2_cp <= m2b_cp; d2_sp <= m2b_sp;

      // Rotation by the position angle
      m3amode <= d2mode;
      m3a_p[0] <= mul_part(d2_l, d2_cp);
      m3a_p[1] <= mul_part(d2_m, d2_sp);
      m3a_p[2] <= mul_part(d2_m, d2_cp);
      m3a_p[3] <= mul_part(d2_l, d2_sp);
      m3a_l <= d2_l; m3a_m <= d2_m;

      m3bmode <= m3amode;
      for (int j = 0; j < 4; j++) m3b_r[j] <= mul_done(m3a_p[j]);
      m3b_l <= m3a_l; m3b_m <= m3a_m;

      // Pass through unrotated values in plain mode
      r3_l <= m3bmode ? m3b_r[0] + m3b_r[1] : m3b_l;
      r3_m <= m3bmode ? m3b_r[2] - m3b_r[3] : m3b_m;

      m4a_p[0] <= mul_part(r3_l, r3_l);
      m4a_p[1] <= mul_part(r3_m, r3_m);
      m4a_l <= r3_l; m4a_m <= r3_m;

      m4b_ll <= mul_done(m4a_p[0]);
      m4b_mm <= mul_done(m4a_p[1]);
      m4b_l <= m4a_l; m4b_m <= m4a_m;

      // Radicand: test t^2 < d*2^WF + 2^(WF-1), i.e. round(t^2) <= d
      sq[0].flag <= d4_d[63];
      sq[0].rem <= d4_d[63] ? '0
                 : ({1'b0, d4_d[WF:0], {WF{1'b0}}} | (REM_BITS'(1) << (WF - 1)));
      sq[0].y <= '0;
      sq[0].lo <= to_out(m4b_l);
      sq[0].mo <= to_out(m4b_m);
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring square root, one result bit per stage, MSB first
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
    localparam int unsigned BIT = WF - j;
    logic [REM_BITS-1:0] trial;

    assign trial = ({{(REM_BITS - ROOT_BITS){1'b0}}, sq[j].y} << (BIT + 1))
                 | (REM_BITS'(1) << (2 * BIT));

    always_ff @(posedge clk) begin
      if (rst) sv[j+1] <= 1'b0;
      else if (adv) sv[j+1] <= sv[j];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq[j+1].flag <= sq[j].flag;
        sq[j+1].lo <= sq[j].lo;
        sq[j+1].mo <= sq[j].mo;
        if (sq[j].rem > trial) begin
          sq[j+1].rem <= sq[j].rem - trial;
          sq[j+1].y <= sq[j].y | (ROOT_BITS'(1) << BIT);
        end else begin
          sq[j+1].rem <= sq[j].rem;
          sq[j+1].y <= sq[j].y;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic signed [31:0] n_full;
  assign n_full = to_out($signed({{(64 - ROOT_BITS){1'b0}}, sq[ROOT_BITS].y}));

  assign adv = !out_hold || !sv[ROOT_BITS];
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (!out_hold) out_valid <= sv[ROOT_BITS];
  end

  always_ff @(posedge clk) begin
    if (!out_hold) begin
      l_cosine <= sq[ROOT_BITS].lo;
      m_cosine <= sq[ROOT_BITS].mo;
      n_clamped <= sq[ROOT_BITS].flag;
      // Drop n to zero when the radicand went negative
      n_cosine <= sq[ROOT_BITS].flag ? '0 : n_full[30:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RLMN_ASSERT_IMP(a_clamp_zero, out_valid && n_clamped, n_cosine == '0)
  `RLMN_ASSERT_IMP(a_full_blocks, out_valid && out_stall && sv[ROOT_BITS], in_stall)
  `RLMN_ASSERT_NEXT(a_enter, in_valid && !in_stall, cv[0])
  `RLMN_ASSERT_IMP(a_l_range, out_valid, (l_cosine <= OUT_ONE) && (l_cosine >= -OUT_ONE))

endmodule
